@@ sv/ppb_pkg.sv @@
// Shared types, constants and format tables for the packed pixel blend block.
package ppb_pkg;

   typedef enum logic [1:0] {
      FmtRgb332   = 2'd0,
      FmtRgb555   = 2'd1,
      FmtRgb565   = 2'd2,
      FmtArgb8888 = 2'd3
   } pixel_format_type;

   typedef enum logic [1:0] {
      ModeKeyed    = 2'd0,
      ModeAbsolute = 2'd1,
      ModeAdditive = 2'd2
   } blend_mode_type;

   typedef enum logic [1:0] {
      RegFormat = 2'd0,
      RegMode   = 2'd1,
      RegAlpha  = 2'd2
   } reg_index_type;

   localparam int unsigned PixelWidth = 32;
   localparam int unsigned ChanWidth  = 8;
   localparam int unsigned AlphaWidth = 9;
   localparam int unsigned ShiftWidth = 5;
   localparam int unsigned NumLanes   = 4;
   localparam logic [AlphaWidth-1:0] AlphaOne = 9'd256;

   typedef struct packed {
      pixel_format_type          fmt;
      blend_mode_type            mode;
      logic [AlphaWidth-1:0]     alpha;
   } cfg_type;

   function automatic logic [PixelWidth-1:0] fmt_mask(input pixel_format_type fmt);
      logic [PixelWidth-1:0] m;
      case (fmt)
         FmtRgb332:   m = 32'h0000_00FF;
         FmtRgb555:   m = 32'h0000_7FFF;
         FmtRgb565:   m = 32'h0000_FFFF;
         FmtArgb8888: m = 32'hFFFF_FFFF;
         default:     m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [ShiftWidth-1:0] chan_shift(input pixel_format_type fmt,
                                                        input logic [1:0] c);
      logic [ShiftWidth-1:0] sh;
      case (fmt)
         FmtRgb332: begin
            case (c)
               2'd0:    sh = 5'd5;
               2'd1:    sh = 5'd2;
               default: sh = 5'd0;
            endcase
         end
         FmtRgb555: begin
            case (c)
               2'd0:    sh = 5'd10;
               2'd1:    sh = 5'd5;
               default: sh = 5'd0;
            endcase
         end
         FmtRgb565: begin
            case (c)
               2'd0:    sh = 5'd11;
               2'd1:    sh = 5'd5;
               default: sh = 5'd0;
            endcase
         end
         default: begin
            case (c)
               2'd0:    sh = 5'd24;
               2'd1:    sh = 5'd16;
               2'd2:    sh = 5'd8;
               default: sh = 5'd0;
            endcase
         end
      endcase
      return sh;
   endfunction

   function automatic logic [ChanWidth-1:0] chan_max(input pixel_format_type fmt,
                                                     input logic [1:0] c);
      logic [ChanWidth-1:0] m;
      case (fmt)
         FmtRgb332: begin
            case (c)
               2'd0:    m = 8'h07;
               2'd1:    m = 8'h07;
               2'd2:    m = 8'h03;
               default: m = 8'h00;
            endcase
         end
         FmtRgb555: begin
            case (c)
               2'd3:    m = 8'h00;
               default: m = 8'h1F;
            endcase
         end
         FmtRgb565: begin
            case (c)
               2'd1:    m = 8'h3F;
               2'd3:    m = 8'h00;
               default: m = 8'h1F;
            endcase
         end
         default: m = 8'hFF;
      endcase
      return m;
   endfunction

endpackage

@@ sv/ppb_lane.sv @@
// One colour channel: weighted blend and saturating sum of a source and destination value.
module ppb_lane (
   input  logic [ppb_pkg::ChanWidth-1:0]  src_chan,
   input  logic [ppb_pkg::ChanWidth-1:0]  dst_chan,
   input  logic [ppb_pkg::ChanWidth-1:0]  chan_max,
   input  logic [ppb_pkg::AlphaWidth-1:0] alpha,
   output logic [ppb_pkg::ChanWidth-1:0]  blend_chan,
   output logic [ppb_pkg::ChanWidth-1:0]  add_chan
);

   logic [ppb_pkg::AlphaWidth-1:0] inv_alpha;
   logic [16:0]                    prod_src;
   logic [16:0]                    prod_dst;
   logic [16:0]                    prod_sum;
   logic [ppb_pkg::ChanWidth:0]    chan_sum;

   always_comb begin
      inv_alpha  = ppb_pkg::AlphaOne - alpha;
      prod_src   = 17'(alpha) * 17'(src_chan);
      prod_dst   = 17'(inv_alpha) * 17'(dst_chan);
      prod_sum   = prod_src + prod_dst;
      blend_chan = prod_sum[15:8] & chan_max;
      chan_sum   = {1'b0, src_chan} + {1'b0, dst_chan};
      add_chan   = (chan_sum > {1'b0, chan_max}) ? chan_max : chan_sum[ppb_pkg::ChanWidth-1:0];
   end

endmodule

@@ sv/ppb_datapath.sv @@
// Combinational pixel path: format masking, channel lanes and mode selection.
module ppb_datapath (
   input  ppb_pkg::cfg_type                cfg,
   input  logic [ppb_pkg::PixelWidth-1:0]  src_pixel,
   input  logic [ppb_pkg::PixelWidth-1:0]  dst_pixel,
   output logic [ppb_pkg::PixelWidth-1:0]  new_pixel,
   output logic                            write_enable
);

   logic [ppb_pkg::PixelWidth-1:0] src_m;
   logic [ppb_pkg::PixelWidth-1:0] dst_m;
   logic [ppb_pkg::AlphaWidth-1:0] alpha_c;
   logic [ppb_pkg::PixelWidth-1:0] blend_part [ppb_pkg::NumLanes];
   logic [ppb_pkg::PixelWidth-1:0] add_part   [ppb_pkg::NumLanes];
   logic [ppb_pkg::PixelWidth-1:0] blend_pixel;
   logic [ppb_pkg::PixelWidth-1:0] add_pixel;

   assign src_m   = src_pixel & ppb_pkg::fmt_mask(cfg.fmt);
   assign dst_m   = dst_pixel & ppb_pkg::fmt_mask(cfg.fmt);
   assign alpha_c = cfg.alpha[ppb_pkg::AlphaWidth-1] ? ppb_pkg::AlphaOne : cfg.alpha;

   for (genvar c = 0; c < ppb_pkg::NumLanes; c++) begin : g_lane
      logic [ppb_pkg::ShiftWidth-1:0] sh;
      logic [ppb_pkg::ChanWidth-1:0]  mx;
      logic [ppb_pkg::ChanWidth-1:0]  sc;
      logic [ppb_pkg::ChanWidth-1:0]  dc;
      logic [ppb_pkg::ChanWidth-1:0]  bv;
      logic [ppb_pkg::ChanWidth-1:0]  av;

      assign sh = ppb_pkg::chan_shift(cfg.fmt, 2'(c));
      assign mx = ppb_pkg::chan_max(cfg.fmt, 2'(c));
      assign sc = ppb_pkg::ChanWidth'(src_m >> sh) & mx;
      assign dc = ppb_pkg::ChanWidth'(dst_m >> sh) & mx;

      ppb_lane u_lane (
         .src_chan   (sc),
         .dst_chan   (dc),
         .chan_max   (mx),
         .alpha      (alpha_c),
         .blend_chan (bv),
         .add_chan   (av)
      );

      assign blend_part[c] = ppb_pkg::PixelWidth'(bv) << sh;
      // The alpha byte of an ARGB8888 sum is cleared.
      if (c == 0) begin : g_alpha
         assign add_part[c] = (cfg.fmt == ppb_pkg::FmtArgb8888) ? '0
                                                                : ppb_pkg::PixelWidth'(av) << sh;
      end else begin : g_colour
         assign add_part[c] = ppb_pkg::PixelWidth'(av) << sh;
      end
   end

   assign blend_pixel = blend_part[0] | blend_part[1] | blend_part[2] | blend_part[3];
   assign add_pixel   = add_part[0] | add_part[1] | add_part[2] | add_part[3];

   always_comb begin
      new_pixel    = dst_m;
      write_enable = 1'b0;
      case (cfg.mode)
         ppb_pkg::ModeKeyed: begin
            if (src_m != '0) begin
               new_pixel    = (alpha_c == ppb_pkg::AlphaOne) ? src_m : blend_pixel;
               write_enable = 1'b1;
            end
         end
         ppb_pkg::ModeAbsolute: begin
            new_pixel    = src_m;
            write_enable = 1'b1;
         end
         ppb_pkg::ModeAdditive: begin
            new_pixel    = add_pixel;
            write_enable = 1'b1;
         end
         default: begin
            new_pixel    = dst_m;
            write_enable = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/packed_pixel_blend_top.sv @@
// Packed pixel blend: register bank, input register, blend path and result register.
//
// The req channel carries one word per pixel pair: source pixel and destination
// pixel in the packed format held in the format register. The rsp channel returns
// the pixel to store in tdata and its write enable in tuser.
// The csr port writes pixel format, blend mode and alpha; writes take effect at
// once. The user must make writes only while no word is in flight; the block
// does not enforce this. A word accepted on req is held in the input register,
// blended there and moved into the result register, from which rsp shows it.
// Throughput is one word per cycle while rsp is not stalled; each register takes
// a new word whenever it is empty or the word it holds is being passed on.
// When the receiver stalls, the result register holds its word, the input register
// fills behind it and req_tready then falls until rsp is taken.
// Reset empties both registers and sets format ARGB8888, keyed blend mode and
// opaque alpha.
module packed_pixel_blend_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // source_pixel [31:0], dest_pixel [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // new_pixel [31:0]
   output logic        rsp_tuser,   // write_enable [0]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [8:0]  csr_wdata
);

   ppb_pkg::pixel_format_type fmt_ff, fmt_in;
   ppb_pkg::blend_mode_type   mode_ff, mode_in;
   logic [8:0]                alpha_ff, alpha_in;

   logic        in_vld_ff, in_vld_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;

   logic        out_vld_ff, out_vld_in;
   logic [31:0] pix_ff, pix_in;
   logic        we_ff, we_in;

   logic             out_ready;
   ppb_pkg::cfg_type cfg;
   logic [31:0]      new_pixel;
   logic             write_enable;

   always_comb begin
      fmt_in   = fmt_ff;
      mode_in  = mode_ff;
      alpha_in = alpha_ff;
      if (csr_we) begin
         case (ppb_pkg::reg_index_type'(csr_addr))
            ppb_pkg::RegFormat: fmt_in   = ppb_pkg::pixel_format_type'(csr_wdata[1:0]);
            ppb_pkg::RegMode:   mode_in  = ppb_pkg::blend_mode_type'(csr_wdata[1:0]);
            ppb_pkg::RegAlpha:  alpha_in = csr_wdata;
            default: begin
               fmt_in = fmt_ff;
            end
         endcase
      end
   end

   assign out_ready  = !out_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || out_ready;

   assign cfg.fmt   = fmt_ff;
   assign cfg.mode  = mode_ff;
   assign cfg.alpha = alpha_ff;

   ppb_datapath u_datapath (
      .cfg          (cfg),
      .src_pixel    (src_ff),
      .dst_pixel    (dst_ff),
      .new_pixel    (new_pixel),
      .write_enable (write_enable)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      if (req_tready) begin
         in_vld_in = req_tvalid;
         src_in    = req_tdata[31:0];
         dst_in    = req_tdata[63:32];
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      pix_in     = pix_ff;
      we_in      = we_ff;
      if (out_ready) begin
         out_vld_in = in_vld_ff;
         pix_in     = new_pixel;
         we_in      = write_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= ppb_pkg::FmtArgb8888;
         mode_ff    <= ppb_pkg::ModeKeyed;
         alpha_ff   <= ppb_pkg::AlphaOne;
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         fmt_ff     <= fmt_in;
         mode_ff    <= mode_in;
         alpha_ff   <= alpha_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      dst_ff <= dst_in;
      pix_ff <= pix_in;
      we_ff  <= we_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = pix_ff;
   assign rsp_tuser  = we_ff;

`ifndef SYNTH
   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && out_vld_ff && !rsp_tready) |-> !req_tready)
      else $error("input register overwritten while result stalled");

   a_word_advances: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && out_ready) |=> rsp_tvalid)
      else $error("registered word did not reach the result register");

   a_no_write_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
      (mode_ff != ppb_pkg::ModeAbsolute && mode_ff != ppb_pkg::ModeAdditive))
      else $error("write enable low in a mode that always writes");

   a_upper_bits_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata & ~ppb_pkg::fmt_mask(fmt_ff)) == 32'h0))
      else $error("result has bits set above the pixel format width");
`endif

endmodule
